// File: hw/rtl/imufp_pkg.sv
// ----------------------------------------------------------------------------
// imufp_pkg
// Shared types and constants for the inertial sensor frame parser.
// ----------------------------------------------------------------------------
package imufp_pkg;

  // Frame layout.
  localparam logic [7:0] HDR_BYTE     = 8'h55;
  localparam logic [3:0] FIRST_DATA   = 4'd2;   // position of the first payload byte
  localparam logic [3:0] SUM_POS      = 4'd10;  // position of the checksum byte

  // Configuration register indexes and reset values.
  localparam int unsigned CFG_IDX_W   = 1;
  localparam logic [CFG_IDX_W-1:0] REG_TYPE_FIRST = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TYPE_LAST  = 1'd1;
  localparam logic [7:0] TYPE_FIRST_RST = 8'h51;
  localparam logic [7:0] TYPE_LAST_RST  = 8'h53;

  // Framing phase.
  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_TYPE = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  // Verified frame as delivered on the result channel.
  typedef struct packed {
    logic [7:0]         frame_type;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic signed [15:0] extra_word;
  } frame_t;

  // Framing status seen by the top level.
  typedef struct packed {
    phase_t     phase;
    logic [3:0] byte_index;
    logic       check_ok;   // current word is a matching checksum byte
  } core_status_t;

endpackage

// File: hw/rtl/imufp_if.sv
// ----------------------------------------------------------------------------
// imufp_if
// Valid/ready channels for received bytes and verified frames.
// ----------------------------------------------------------------------------
interface imufp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface imufp_frame_if;
  logic               valid;
  logic               ready;
  logic [7:0]         frame_type;
  logic signed [15:0] axis_x;
  logic signed [15:0] axis_y;
  logic signed [15:0] axis_z;
  logic signed [15:0] extra_word;

  modport source (output valid, output frame_type, output axis_x, output axis_y,
                  output axis_z, output extra_word, input ready);
  modport sink   (input valid, input frame_type, input axis_x, input axis_y,
                  input axis_z, input extra_word, output ready);
endinterface

// File: hw/rtl/imufp_core.sv
// ----------------------------------------------------------------------------
// imufp_core
// Framing state, running checksum and payload store. Advances one byte
// when step is high.
// ----------------------------------------------------------------------------
module imufp_core
  import imufp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  logic [7:0]   data,
  input  logic [7:0]   type_first,
  input  logic [7:0]   type_last,
  output core_status_t status,
  output frame_t       frame
);

  phase_t     phase, phase_next;
  logic [3:0] byte_index, byte_index_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] type_hold, type_hold_next;
  logic [7:0] payload [8];
  logic       store_we;
  logic [2:0] store_addr;
  logic       in_range;

  assign in_range   = (data >= type_first) && (data <= type_last);
  assign store_addr = 3'(byte_index - FIRST_DATA);

  // Next state of the framing sequencer.
  always_comb begin
    phase_next       = phase;
    byte_index_next  = byte_index;
    running_sum_next = running_sum;
    type_hold_next   = type_hold;
    store_we         = 1'b0;
    if (step) begin
      unique case (phase)
        PH_TYPE: begin
          if (in_range) begin
            type_hold_next   = data;
            running_sum_next = HDR_BYTE + data;
            byte_index_next  = FIRST_DATA;
            phase_next       = PH_DATA;
          end else begin
            phase_next = PH_HUNT;
          end
        end
        PH_DATA: begin
          if (byte_index < SUM_POS) begin
            store_we         = 1'b1;
            running_sum_next = running_sum + data;
            byte_index_next  = byte_index + 4'd1;
          end else begin
            phase_next      = PH_HUNT;
            byte_index_next = 4'd0;
          end
        end
        default: begin
          phase_next = (data == HDR_BYTE) ? PH_TYPE : PH_HUNT;
        end
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      byte_index  <= 4'd0;
      running_sum <= 8'd0;
      type_hold   <= 8'd0;
    end else begin
      phase       <= phase_next;
      byte_index  <= byte_index_next;
      running_sum <= running_sum_next;
      type_hold   <= type_hold_next;
    end
  end

  // Payload bytes; every entry is written before the checksum byte arrives.
  always_ff @(posedge clk) begin
    if (store_we) begin
      payload[store_addr] <= data;
    end
  end

  // The current byte closes a frame with a matching checksum.
  assign status.phase      = phase;
  assign status.byte_index = byte_index;
  assign status.check_ok   = (phase == PH_DATA) && (byte_index >= SUM_POS) &&
                             (running_sum == data);

  // Little-endian words from the payload store.
  assign frame.frame_type = type_hold;
  assign frame.axis_x     = {payload[1], payload[0]};
  assign frame.axis_y     = {payload[3], payload[2]};
  assign frame.axis_z     = {payload[5], payload[4]};
  assign frame.extra_word = {payload[7], payload[6]};

endmodule

// File: hw/rtl/imu_frame_parser.sv
// ----------------------------------------------------------------------------
// imu_frame_parser
// Byte-serial parser for 11-byte inertial sensor frames with checksum.
// ----------------------------------------------------------------------------
//   channel  dir  handshake         payload
//   rx       in   valid / ready     in_byte
//   frame    out  valid / ready     frame_type, axis_x, axis_y, axis_z, extra_word
//   cfg      in   cfg_we            cfg_index, cfg_wdata
//
// One byte word is taken per cycle unless a matching checksum byte waits on a
// full output. A byte is registered on arrival and processed from the input
// register; a verified frame shows on the output register in the cycle after
// its checksum byte is processed. Reset clears the framing state and sets the
// type range to 0x51..0x53. A held result stalls only the checksum byte of the
// next good frame; bytes ahead of it keep flowing while the output waits.
// ----------------------------------------------------------------------------
module imu_frame_parser
  import imufp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  imufp_byte_if.sink           rx,
  imufp_frame_if.source        frame,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_wdata
);

  logic [7:0]   type_first, type_last;
  logic         stage_valid;
  logic [7:0]   stage_byte;
  logic         out_valid;
  frame_t       out_frame;
  frame_t       core_frame;
  core_status_t status;
  logic         out_free;
  logic         fire;
  logic         load;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      type_first <= TYPE_FIRST_RST;
      type_last  <= TYPE_LAST_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TYPE_FIRST: type_first <= cfg_wdata;
        REG_TYPE_LAST:  type_last  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The staged byte moves on unless it is a matching checksum byte and the output is full.
  assign out_free = !out_valid || frame.ready;
  assign fire     = stage_valid && (!status.check_ok || out_free);
  assign load     = fire && status.check_ok;
  assign rx.ready = !stage_valid || fire;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (rx.ready) begin
      stage_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      stage_byte <= rx.in_byte;
    end
  end

  imufp_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (fire),
    .data       (stage_byte),
    .type_first (type_first),
    .type_last  (type_last),
    .status     (status),
    .frame      (core_frame)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (frame.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_frame <= core_frame;
    end
  end

  assign frame.valid      = out_valid;
  assign frame.frame_type = out_frame.frame_type;
  assign frame.axis_x     = out_frame.axis_x;
  assign frame.axis_y     = out_frame.axis_y;
  assign frame.axis_z     = out_frame.axis_z;
  assign frame.extra_word = out_frame.extra_word;

  // A result is never loaded over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    !(load && out_valid && !frame.ready))
    else $error("result overwritten while held");

  // A result comes only from the checksum byte of a frame.
  a_load_at_sum: assert property (@(posedge clk) disable iff (rst)
    load |-> (status.phase == PH_DATA) && (status.byte_index == SUM_POS))
    else $error("result loaded outside checksum position");

  // Byte position stays within the frame while receiving.
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    (status.phase == PH_DATA) |->
      (status.byte_index >= FIRST_DATA) && (status.byte_index <= SUM_POS))
    else $error("byte index out of range");

  // A loaded result is presented in the next cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load |=> out_valid)
    else $error("loaded result not presented");

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the inertial sensor frame parser. Byte words are
// fed through the receive channel with random gaps while the frame channel
// stalls at random. A tracking model follows the framing state and the type
// range, and every verified frame is compared field by field with the
// oldest frame it expects.
// ----------------------------------------------------------------------------
module tb;
  import imufp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE      = 6;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0] cfg_wdata;

  imufp_byte_if  rx_ch ();
  imufp_frame_if frm_ch ();

  imu_frame_parser dut (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx_ch),
    .frame     (frm_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Tracking copy of the parser state and its type range.
  phase_t     trk_phase;
  logic [3:0] trk_pos;
  logic [7:0] trk_sum;
  logic [7:0] trk_type;
  logic [7:0] trk_first;
  logic [7:0] trk_last;
  logic [7:0] trk_data [8];

  frame_t      frames_due [$];
  int unsigned errors;
  int unsigned cycles;
  int unsigned words_sent;
  bit          calm;
  logic [7:0]  range_lo;
  logic [7:0]  range_hi;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void clear_tracking();
    trk_phase = PH_HUNT;
    trk_pos   = '0;
    trk_sum   = '0;
    trk_type  = '0;
    trk_first = TYPE_FIRST_RST;
    trk_last  = TYPE_LAST_RST;
    for (int i = 0; i < 8; i++) trk_data[i] = '0;
  endfunction

  // Advance the framing state by one received byte and queue any frame it
  // completes.
  function automatic void parse_byte(logic [7:0] b);
    frame_t f;
    case (trk_phase)
      PH_TYPE: begin
        if (b >= trk_first && b <= trk_last) begin
          trk_type  = b;
          trk_sum   = 8'(HDR_BYTE + b);
          trk_pos   = FIRST_DATA;
          trk_phase = PH_DATA;
        end else begin
          trk_phase = PH_HUNT;
        end
      end
      PH_DATA: begin
        if (trk_pos < SUM_POS) begin
          trk_data[3'(trk_pos - FIRST_DATA)] = b;
          trk_sum = 8'(trk_sum + b);
          trk_pos = 4'(trk_pos + 1);
        end else begin
          trk_phase = PH_HUNT;
          trk_pos   = '0;
          if (trk_sum == b) begin
            f.frame_type = trk_type;
            f.axis_x     = {trk_data[1], trk_data[0]};
            f.axis_y     = {trk_data[3], trk_data[2]};
            f.axis_z     = {trk_data[5], trk_data[4]};
            f.extra_word = {trk_data[7], trk_data[6]};
            frames_due.push_back(f);
          end
        end
      end
      default: begin
        trk_phase = (b == HDR_BYTE) ? PH_TYPE : PH_HUNT;
      end
    endcase
  endfunction

  // Follow accepted words and register writes; check each delivered frame.
  always @(posedge clk) begin
    frame_t want;
    frame_t got;
    if (rst) begin
      clear_tracking();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_TYPE_FIRST) trk_first = cfg_wdata;
        if (cfg_index == REG_TYPE_LAST) trk_last = cfg_wdata;
      end
      if (rx_ch.valid && rx_ch.ready) parse_byte(rx_ch.in_byte);
      if (frm_ch.valid && frm_ch.ready) begin
        got.frame_type = frm_ch.frame_type;
        got.axis_x     = frm_ch.axis_x;
        got.axis_y     = frm_ch.axis_y;
        got.axis_z     = frm_ch.axis_z;
        got.extra_word = frm_ch.extra_word;
        if (frames_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected frame: type %02h x %04h y %04h z %04h w %04h",
                     got.frame_type, got.axis_x, got.axis_y, got.axis_z, got.extra_word);
        end else begin
          want = frames_due.pop_front();
          if (got.frame_type !== want.frame_type || got.axis_x !== want.axis_x ||
              got.axis_y !== want.axis_y || got.axis_z !== want.axis_z ||
              got.extra_word !== want.extra_word) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected type %02h x %04h y %04h z %04h w %04h,",
                       want.frame_type, want.axis_x, want.axis_y, want.axis_z,
                       want.extra_word,
                       " got type %02h x %04h y %04h z %04h w %04h",
                       got.frame_type, got.axis_x, got.axis_y,
                       got.axis_z, got.extra_word);
          end
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // Frame receiver: a random stall before each word unless traffic is calm.
  initial begin
    int unsigned stall;
    forever begin
      stall = calm ? 0 : $urandom_range(0, 7);
      repeat (stall) begin
        frm_ch.ready <= 1'b0;
        @(posedge clk);
      end
      frm_ch.ready <= 1'b1;
      do @(posedge clk); while (!frm_ch.valid);
    end
  end

  // Send one byte word; valid stays high after acceptance.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    repeat (gap) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.in_byte <= b;
    do @(posedge clk); while (!rx_ch.ready);
    words_sent++;
  endtask

  // Send a whole frame; payload byte i sits in bits 8*i and up.
  task automatic send_frame(input logic [7:0] ty, input logic [63:0] pl, input bit good);
    logic [7:0] sum;
    sum = 8'(HDR_BYTE + ty);
    for (int i = 0; i < 8; i++) sum = 8'(sum + pl[8*i +: 8]);
    if (!good) sum = 8'(sum + $urandom_range(1, 255));
    send_byte(HDR_BYTE);
    send_byte(ty);
    for (int i = 0; i < 8; i++) send_byte(pl[8*i +: 8]);
    send_byte(sum);
  endtask

  // Drain all pending frames, then let the pipeline settle.
  task automatic wait_idle();
    rx_ch.valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_range(input logic [7:0] lo, input logic [7:0] hi);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_TYPE_FIRST;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_index <= REG_TYPE_LAST;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_we <= 1'b0;
    range_lo = lo;
    range_hi = hi;
  endtask

  // Payload bytes lean toward the edges and the header value.
  function automatic logic [7:0] payload_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return HDR_BYTE;
      3: return 8'h80;
      4: return 8'h7F;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [63:0] random_payload();
    logic [63:0] pl;
    for (int i = 0; i < 8; i++) pl[8*i +: 8] = payload_byte();
    return pl;
  endfunction

  function automatic logic [7:0] pick_type();
    if (range_lo <= range_hi && $urandom_range(0, 7) != 0)
      return 8'($urandom_range(range_hi, range_lo));
    return 8'($urandom_range(0, 255));
  endfunction

  // Mostly whole frames with random content, plus cut-off frames, loose
  // bytes and random type bytes after a header.
  task automatic random_traffic(input int unsigned n_words);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned k;
    logic [7:0] ty;
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0) calm = ~calm;
      pick = $urandom_range(0, 99);
      ty   = pick_type();
      if (pick < 70) begin
        send_frame(ty, random_payload(), $urandom_range(0, 6) != 0);
      end else if (pick < 80) begin
        send_byte(HDR_BYTE);
        send_byte(ty);
        k = $urandom_range(0, 8);
        repeat (k) send_byte(payload_byte());
      end else if (pick < 90) begin
        k = $urandom_range(1, 4);
        repeat (k) send_byte(($urandom_range(0, 3) == 0) ? HDR_BYTE : 8'($urandom_range(0, 255)));
      end else begin
        send_byte(HDR_BYTE);
        send_byte(8'($urandom_range(0, 255)));
      end
    end
    calm = 1'b0;
  endtask

  // Reset range: edge types, header byte in the type slot and the payload,
  // out-of-range types and a bad checksum.
  task automatic test_default_range();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(8'h51, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_byte(HDR_BYTE);
    send_byte(HDR_BYTE);
    send_frame(8'h53, 64'h00FF_557F_8000_5555, 1'b1);
    send_byte(HDR_BYTE);
    send_byte(8'h50);
    send_byte(HDR_BYTE);
    send_byte(8'h54);
    send_frame(8'h52, 64'h0, 1'b0);
    send_frame(8'h52, 64'h7FFF_8000_00FF_807F, 1'b1);
    random_traffic(300);
  endtask

  // Whole type range, so the header value is a valid type.
  task automatic test_full_range();
    set_range(8'h00, 8'hFF);
    send_frame(8'h00, 64'h8000_8000_8000_8000, 1'b1);
    send_frame(8'hFF, 64'h7FFF_7FFF_7FFF_7FFF, 1'b1);
    send_frame(HDR_BYTE, random_payload(), 1'b1);
    random_traffic(300);
  endtask

  // One accepted type at each end of the byte range.
  task automatic test_single_type();
    set_range(8'hFF, 8'hFF);
    send_frame(8'hFF, random_payload(), 1'b1);
    send_frame(8'hFE, random_payload(), 1'b1);
    random_traffic(150);
    set_range(8'h00, 8'h00);
    send_frame(8'h00, random_payload(), 1'b1);
    send_frame(8'h01, random_payload(), 1'b1);
    random_traffic(150);
  endtask

  // Inverted range: nothing may come out.
  task automatic test_empty_range();
    set_range(8'hFF, 8'h00);
    send_frame(8'h00, random_payload(), 1'b1);
    send_frame(8'hFF, random_payload(), 1'b1);
    random_traffic(120);
    set_range(8'h80, 8'h7F);
    send_frame(8'h80, random_payload(), 1'b1);
    random_traffic(80);
  endtask

  task automatic test_random_ranges();
    logic [7:0] a;
    logic [7:0] b;
    repeat (3) begin
      a = 8'($urandom_range(0, 255));
      b = 8'($urandom_range(0, 255));
      if (a > b) set_range(b, a);
      else set_range(a, b);
      random_traffic(120);
    end
  endtask

  task automatic test_reset_range_again();
    set_range(TYPE_FIRST_RST, TYPE_LAST_RST);
    random_traffic(250);
  endtask

  initial begin
    rst           <= 1'b1;
    rx_ch.valid   <= 1'b0;
    rx_ch.in_byte <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= '0;
    cfg_wdata     <= '0;
    errors        = 0;
    cycles        = 0;
    words_sent    = 0;
    calm          = 1'b0;
    range_lo      = TYPE_FIRST_RST;
    range_hi      = TYPE_LAST_RST;
    clear_tracking();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_range();
    test_full_range();
    test_single_type();
    test_empty_range();
    test_random_ranges();
    test_reset_range_again();

    wait_idle();
    repeat (SETTLE) @(posedge clk);
    if (errors == 0 && frames_due.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/imufp_pkg.sv
hw/rtl/imufp_if.sv
hw/rtl/imufp_core.sv
hw/rtl/imu_frame_parser.sv
test/tb.sv
